>>> sv/lfuc_pkg.sv
package lfuc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 17;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int CAP_W          = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_TOUCH,
    ST_DONE
  } state_e;

  // Strobes from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
  } store_ctl_t;

  // Result flags, hit in the low bit.
  typedef struct packed {
    logic evicted;
    logic hit;
  } res_flags_t;

endpackage

>>> sv/lfu_cache_lru_tiebreak_unit.sv
// Channel   Dir  Word                                        Accept
// s_axis    in   tuser: action; tdata: key, value            tvalid & tready
// m_axis    out  tuser: hit, evicted; tdata: read_value,     tvalid & tready
//                evicted_key
// cfg       in   capacity_in_use                             cfg_we_i
//
// A get that misses ends after the lookup pass; every other access also
// writes its entry and makes a recency pass. The entry memory has
// one read port: a lookup pass reads every entry once, and a recency pass
// reads every entry once more and rewrites the ones that age.
// Reset clears valid marks, occupancy and the output valid flag; capacity
// resets to 16. A finished word waits in the output register while the next
// word is accepted; a stalled master holds the next result in the sequencer.
module lfu_cache_lru_tiebreak_unit #(
  parameter int ENTRIES    = lfuc_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // key, value
  input  logic                       s_axis_tuser,  // action
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,  // read_value, evicted_key
  output logic [1:0]                 m_axis_tuser,  // hit, evicted
  input  logic                       cfg_we_i,
  input  logic [lfuc_pkg::CAP_W-1:0] cfg_wdata_i
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = lfuc_pkg::KEY_W + lfuc_pkg::VAL_W + COUNT_BITS + IDX_W;

  logic [lfuc_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]           cap_eff;

  logic                       start;
  logic                       seq_idle;
  logic                       seq_done;
  logic                       out_free;
  logic                       res_take;
  lfuc_pkg::res_flags_t       flags;
  logic [lfuc_pkg::VAL_W-1:0] read_value;
  logic [lfuc_pkg::KEY_W-1:0] evicted_key;

  lfuc_pkg::store_ctl_t       ctl;
  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           wr_addr;
  logic [WORD_W-1:0]          wr_data;
  logic [WORD_W-1:0]          rd_data;
  logic [ENTRIES-1:0]         valid;

  logic                       m_valid_q;
  logic [63:0]                m_data_q;
  lfuc_pkg::res_flags_t       m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfuc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Zero acts as one; above the entry count saturates.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign s_axis_tready = seq_idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign res_take      = seq_done && out_free;

  lfuc_seq #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .WORD_W     (WORD_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .action_i      (s_axis_tuser),
    .key_i         (s_axis_tdata[31:0]),
    .value_i       (s_axis_tdata[63:32]),
    .cap_i         (cap_eff),
    .res_take_i    (res_take),
    .idle_o        (seq_idle),
    .done_o        (seq_done),
    .flags_o       (flags),
    .read_value_o  (read_value),
    .evicted_key_o (evicted_key),
    .ctl_o         (ctl),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_data_i     (rd_data),
    .valid_i       (valid)
  );

  lfuc_store #(
    .ENTRIES (ENTRIES),
    .WORD_W  (WORD_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .valid_o   (valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      m_data_q <= {evicted_key, read_value};
      m_user_q <= flags;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> sv/lfuc_store.sv
module lfuc_store #(
  parameter int ENTRIES = lfuc_pkg::ENTRIES_DEF,
  parameter int WORD_W  = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lfuc_pkg::store_ctl_t            ctl_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr_i,
  input  logic [WORD_W-1:0]               wr_data_i,
  output logic [WORD_W-1:0]               rd_data_o,
  output logic [ENTRIES-1:0]              valid_o
);

  logic [WORD_W-1:0]  mem_q [ENTRIES];
  logic [WORD_W-1:0]  rd_data_q;
  logic [ENTRIES-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en && ctl_i.set_valid) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

>>> sv/lfuc_seq.sv
module lfuc_seq #(
  parameter int ENTRIES    = lfuc_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W      = $clog2(ENTRIES + 1),
  parameter int WORD_W     = lfuc_pkg::KEY_W + lfuc_pkg::VAL_W + COUNT_BITS + IDX_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          action_i,
  input  logic [lfuc_pkg::KEY_W-1:0]    key_i,
  input  logic [lfuc_pkg::VAL_W-1:0]    value_i,
  input  logic [CNT_W-1:0]              cap_i,
  input  logic                          res_take_i,
  output logic                          idle_o,
  output logic                          done_o,
  output lfuc_pkg::res_flags_t          flags_o,
  output logic [lfuc_pkg::VAL_W-1:0]    read_value_o,
  output logic [lfuc_pkg::KEY_W-1:0]    evicted_key_o,
  output lfuc_pkg::store_ctl_t          ctl_o,
  output logic [IDX_W-1:0]              rd_addr_o,
  output logic [IDX_W-1:0]              wr_addr_o,
  output logic [WORD_W-1:0]             wr_data_o,
  input  logic [WORD_W-1:0]             rd_data_i,
  input  logic [ENTRIES-1:0]            valid_i
);

  localparam int KW      = lfuc_pkg::KEY_W;
  localparam int VW      = lfuc_pkg::VAL_W;
  localparam int VAL_LO  = KW;
  localparam int CNTF_LO = KW + VW;
  localparam int RANK_LO = CNTF_LO + COUNT_BITS;

  lfuc_pkg::state_e state_q, state_d;

  logic                  act_q, act_d;
  logic [KW-1:0]         key_q, key_d;
  logic [VW-1:0]         val_q, val_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  rvalid_q, rvalid_d;
  logic [IDX_W-1:0]      ridx_q, ridx_d;
  logic [CNT_W-1:0]      occ_q, occ_d;

  logic                  found_q, found_d;
  logic [IDX_W-1:0]      fslot_q, fslot_d;
  logic [VW-1:0]         fval_q, fval_d;
  logic [COUNT_BITS-1:0] fcnt_q, fcnt_d;
  logic [IDX_W-1:0]      frank_q, frank_d;

  logic                  free_q, free_d;
  logic [IDX_W-1:0]      free_slot_q, free_slot_d;

  logic                  have_q, have_d;
  logic [IDX_W-1:0]      vslot_q, vslot_d;
  logic [KW-1:0]         vkey_q, vkey_d;
  logic [COUNT_BITS-1:0] vcnt_q, vcnt_d;
  logic [IDX_W-1:0]      vrank_q, vrank_d;

  logic [IDX_W-1:0]      slot_q, slot_d;
  logic [IDX_W-1:0]      old_rank_q, old_rank_d;
  logic                  fill_q, fill_d;
  logic [VW-1:0]         wval_q, wval_d;
  logic [COUNT_BITS-1:0] wcnt_q, wcnt_d;

  logic                  hit_q, hit_d;
  logic                  evd_q, evd_d;
  logic [VW-1:0]         rval_q, rval_d;
  logic [KW-1:0]         evkey_q, evkey_d;

  logic                  issue;
  logic                  pass_end;
  logic [KW-1:0]         e_key;
  logic [VW-1:0]         e_val;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [IDX_W-1:0]      e_rank;
  logic                  e_valid;
  logic                  fill_c;
  logic                  bump_c;

  assign issue    = (idx_q < CNT_W'(ENTRIES));
  assign pass_end = !issue && !rvalid_q;

  assign e_key   = rd_data_i[KW-1:0];
  assign e_val   = rd_data_i[VAL_LO +: VW];
  assign e_cnt   = rd_data_i[CNTF_LO +: COUNT_BITS];
  assign e_rank  = rd_data_i[RANK_LO +: IDX_W];
  assign e_valid = valid_i[ridx_q];

  assign fill_c = !found_q && (act_q == lfuc_pkg::ACT_PUT) && (occ_q < cap_i);
  // Entries more recent than the touched one move back by one.
  assign bump_c = rvalid_q && (ridx_q != slot_q) && e_valid && (e_rank < old_rank_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfuc_pkg::ST_IDLE: begin
        if (start_i) state_d = lfuc_pkg::ST_SCAN;
      end
      lfuc_pkg::ST_SCAN: begin
        if (pass_end) state_d = lfuc_pkg::ST_DECIDE;
      end
      lfuc_pkg::ST_DECIDE: begin
        if (found_q || fill_c || ((act_q == lfuc_pkg::ACT_PUT) && have_q)) begin
          state_d = lfuc_pkg::ST_WRITE;
        end else begin
          state_d = lfuc_pkg::ST_DONE;
        end
      end
      lfuc_pkg::ST_WRITE: state_d = lfuc_pkg::ST_TOUCH;
      lfuc_pkg::ST_TOUCH: begin
        if (pass_end) state_d = lfuc_pkg::ST_DONE;
      end
      lfuc_pkg::ST_DONE: begin
        if (res_take_i) state_d = lfuc_pkg::ST_IDLE;
      end
      default: state_d = lfuc_pkg::ST_IDLE;
    endcase
  end

  // Store strobes
  always_comb begin
    ctl_o     = '0;
    rd_addr_o = idx_q[IDX_W-1:0];
    wr_addr_o = slot_q;
    wr_data_o = {IDX_W'(0), wcnt_q, wval_q, key_q};
    case (state_q)
      lfuc_pkg::ST_SCAN: ctl_o.rd_en = issue;
      lfuc_pkg::ST_WRITE: begin
        ctl_o.wr_en     = 1'b1;
        ctl_o.set_valid = fill_q;
      end
      lfuc_pkg::ST_TOUCH: begin
        ctl_o.rd_en = issue;
        if (bump_c) begin
          ctl_o.wr_en = 1'b1;
          wr_addr_o   = ridx_q;
          wr_data_o   = {e_rank + IDX_W'(1), e_cnt, e_val, e_key};
        end
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    occ_d       = occ_q;
    found_d     = found_q;
    fslot_d     = fslot_q;
    fval_d      = fval_q;
    fcnt_d      = fcnt_q;
    frank_d     = frank_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    have_d      = have_q;
    vslot_d     = vslot_q;
    vkey_d      = vkey_q;
    vcnt_d      = vcnt_q;
    vrank_d     = vrank_q;
    slot_d      = slot_q;
    old_rank_d  = old_rank_q;
    fill_d      = fill_q;
    wval_d      = wval_q;
    wcnt_d      = wcnt_q;
    hit_d       = hit_q;
    evd_d       = evd_q;
    rval_d      = rval_q;
    evkey_d     = evkey_q;
    case (state_q)
      lfuc_pkg::ST_IDLE: begin
        if (start_i) begin
          act_d   = action_i;
          key_d   = key_i;
          val_d   = value_i;
          idx_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          have_d  = 1'b0;
          hit_d   = 1'b0;
          evd_d   = 1'b0;
          rval_d  = '0;
          evkey_d = '0;
        end
      end
      lfuc_pkg::ST_SCAN: begin
        if (issue) idx_d = idx_q + CNT_W'(1);
        rvalid_d = issue;
        ridx_d   = idx_q[IDX_W-1:0];
        if (rvalid_q) begin
          if (e_valid && (e_key == key_q) && !found_q) begin
            found_d = 1'b1;
            fslot_d = ridx_q;
            fval_d  = e_val;
            fcnt_d  = e_cnt;
            frank_d = e_rank;
          end
          if (!e_valid && !free_q) begin
            free_d      = 1'b1;
            free_slot_d = ridx_q;
          end
          // Victim: fewest uses, then least recent.
          if (e_valid && (!have_q || (e_cnt < vcnt_q) ||
                          ((e_cnt == vcnt_q) && (e_rank > vrank_q)))) begin
            have_d  = 1'b1;
            vslot_d = ridx_q;
            vkey_d  = e_key;
            vcnt_d  = e_cnt;
            vrank_d = e_rank;
          end
        end
      end
      lfuc_pkg::ST_DECIDE: begin
        fill_d = fill_c;
        wval_d = val_q;
        wcnt_d = COUNT_BITS'(1);
        if (found_q) begin
          hit_d      = 1'b1;
          slot_d     = fslot_q;
          old_rank_d = frank_q;
          wcnt_d     = (fcnt_q == '1) ? fcnt_q : fcnt_q + COUNT_BITS'(1);
          if (act_q == lfuc_pkg::ACT_GET) begin
            rval_d = fval_q;
            wval_d = fval_q;
          end
        end else if (fill_c) begin
          slot_d     = free_slot_q;
          old_rank_d = occ_q[IDX_W-1:0];
          occ_d      = occ_q + CNT_W'(1);
        end else if ((act_q == lfuc_pkg::ACT_PUT) && have_q) begin
          evd_d      = 1'b1;
          evkey_d    = vkey_q;
          slot_d     = vslot_q;
          old_rank_d = vrank_q;
        end
      end
      lfuc_pkg::ST_WRITE: begin
        idx_d = '0;
      end
      lfuc_pkg::ST_TOUCH: begin
        if (issue) idx_d = idx_q + CNT_W'(1);
        rvalid_d = issue;
        ridx_d   = idx_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lfuc_pkg::ST_IDLE;
      idx_q    <= '0;
      rvalid_q <= 1'b0;
      occ_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rvalid_q <= rvalid_d;
      occ_q    <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    key_q       <= key_d;
    val_q       <= val_d;
    ridx_q      <= ridx_d;
    found_q     <= found_d;
    fslot_q     <= fslot_d;
    fval_q      <= fval_d;
    fcnt_q      <= fcnt_d;
    frank_q     <= frank_d;
    free_q      <= free_d;
    free_slot_q <= free_slot_d;
    have_q      <= have_d;
    vslot_q     <= vslot_d;
    vkey_q      <= vkey_d;
    vcnt_q      <= vcnt_d;
    vrank_q     <= vrank_d;
    slot_q      <= slot_d;
    old_rank_q  <= old_rank_d;
    fill_q      <= fill_d;
    wval_q      <= wval_d;
    wcnt_q      <= wcnt_d;
    hit_q       <= hit_d;
    evd_q       <= evd_d;
    rval_q      <= rval_d;
    evkey_q     <= evkey_d;
  end

  assign idle_o          = (state_q == lfuc_pkg::ST_IDLE);
  assign done_o          = (state_q == lfuc_pkg::ST_DONE);
  assign flags_o.hit     = hit_q;
  assign flags_o.evicted = evd_q;
  assign read_value_o    = rval_q;
  assign evicted_key_o   = evkey_q;

endmodule

>>> sv/lfuc_checker.sv
module lfuc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [63:0]                m_axis_tdata,
  input logic [1:0]                 m_axis_tuser
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // One word at a time: drop ready once a word is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready held high after accept");

  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("read value without hit");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("eviction reported on a hit");

  a_evict_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[63:32] == 32'd0))
    else $error("evicted key without eviction");

endmodule

bind lfu_cache_lru_tiebreak_unit lfuc_checker u_lfuc_checker (.*);

>>> tb/sv/lfu_cache_lru_tiebreak_unit_test.sv
`timescale 1ns / 100ps

module lfu_cache_lru_tiebreak_unit_test;
  import lfuc_pkg::*;

  localparam int NSLOT    = ENTRIES_DEF;
  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam int POOL_N   = 24;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_resp_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata  = '0;
  logic             s_axis_tuser  = ACT_GET;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             cfg_we_i      = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i   = '0;

  lfu_cache_lru_tiebreak_unit #(
    .ENTRIES    (NSLOT),
    .COUNT_BITS (CNT_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Shadow copy of the entry store
  logic                shadow_valid [NSLOT];
  logic [KEY_W-1:0]    shadow_key   [NSLOT];
  logic [VAL_W-1:0]    shadow_value [NSLOT];
  logic [CNT_BITS-1:0] shadow_count [NSLOT];
  int                  shadow_rank  [NSLOT];
  int                  shadow_occupancy;
  logic [CAP_W-1:0]    shadow_capacity;

  cache_resp_t cache_resp_q[$];
  logic [KEY_W-1:0] key_pool[POOL_N];

  int  error_count    = 0;
  int  words_sent     = 0;
  int  hits_seen      = 0;
  int  evictions_seen = 0;
  int  cap_settings   = 0;
  bit  tx_gap_en      = 1'b0;
  bit  rx_stall_en    = 1'b0;
  int  rx_hold        = 0;
  int  rx_roll;

  function automatic void reset_shadow();
    for (int i = 0; i < NSLOT; i++) begin
      shadow_valid[i] = 1'b0;
    end
    shadow_occupancy = 0;
    shadow_capacity  = CAP_RESET;
  endfunction

  // Move slot s to most recent; entries more recent than old_rank age by one.
  function automatic void promote_slot(input int s, input int old_rank);
    for (int i = 0; i < NSLOT; i++) begin
      if (i != s && shadow_valid[i] && shadow_rank[i] < old_rank) begin
        shadow_rank[i]++;
      end
    end
    shadow_rank[s] = 0;
  endfunction

  function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > NSLOT) return NSLOT;
    return int'(cap);
  endfunction

  function automatic cache_resp_t cache_access(input logic act, input logic [KEY_W-1:0] k,
                                               input logic [VAL_W-1:0] v);
    cache_resp_t r;
    int  slot;
    bit  found;
    bit  have;
    int  old_rank;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    have  = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!found && shadow_valid[i] && shadow_key[i] == k) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (act == ACT_GET) begin
        r.read_value = shadow_value[slot];
      end else begin
        shadow_value[slot] = v;
      end
      if (shadow_count[slot] != '1) shadow_count[slot]++;
      promote_slot(slot, shadow_rank[slot]);
      return r;
    end
    if (act == ACT_GET) return r;
    if (shadow_occupancy < effective_capacity(shadow_capacity)) begin
      for (int i = NSLOT - 1; i >= 0; i--) begin
        if (!shadow_valid[i]) slot = i;
      end
      shadow_valid[slot] = 1'b1;
      shadow_key[slot]   = k;
      shadow_value[slot] = v;
      shadow_count[slot] = CNT_BITS'(1);
      promote_slot(slot, shadow_occupancy);
      shadow_occupancy++;
    end else begin
      // Fewest uses first, then least recently touched
      for (int i = 0; i < NSLOT; i++) begin
        if (shadow_valid[i]) begin
          if (!have || shadow_count[i] < shadow_count[slot] ||
              (shadow_count[i] == shadow_count[slot] && shadow_rank[i] > shadow_rank[slot])) begin
            slot = i;
            have = 1'b1;
          end
        end
      end
      if (!have) return r;
      r.evicted     = 1'b1;
      r.evicted_key = shadow_key[slot];
      old_rank      = shadow_rank[slot];
      shadow_key[slot]   = k;
      shadow_value[slot] = v;
      shadow_count[slot] = CNT_BITS'(1);
      promote_slot(slot, old_rank);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!tx_gap_en) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high after a word is taken unless a gap follows.
  task automatic send_word(input logic act, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    int          gap;
    cache_resp_t resp;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {v, k};
    do @(posedge clk_i); while (!s_axis_tready);
    resp = cache_access(act, k, v);
    cache_resp_q.insert(cache_resp_q.size(), resp);
    words_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (cache_resp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_capacity = cap;
    cap_settings++;
  endtask

  // Result ready, with random stalls when enabled
  always @(posedge clk_i) begin
    if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 75) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold = (rx_roll < 96) ? $urandom_range(0, 3) : $urandom_range(15, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    cache_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      hits_seen      += int'(m_axis_tuser[0]);
      evictions_seen += int'(m_axis_tuser[1]);
      if (cache_resp_q.size() == 0) begin
        $display("%0t: unexpected result word, actual tuser %b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = cache_resp_q.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b",
                   $time, want.hit, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tdata[31:0] !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, want.read_value, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.evicted) begin
          $display("%0t: evicted mismatch, expected %0b, actual %0b",
                   $time, want.evicted, m_axis_tuser[1]);
          error_count++;
        end
        if (m_axis_tdata[63:32] !== want.evicted_key) begin
          $display("%0t: evicted_key mismatch, expected %h, actual %h",
                   $time, want.evicted_key, m_axis_tdata[63:32]);
          error_count++;
        end
      end
    end
  end

  task automatic test_basic_access();
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
    send_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_word(ACT_GET, 32'h1234_5678, 32'hFFFF_FFFF);
  endtask

  // Two entries: evict by fewest uses, then by age on a count tie
  task automatic test_lru_tiebreak();
    write_capacity(5'd2);
    send_word(ACT_PUT, 32'h0000_0100, 32'h0000_0001);
    send_word(ACT_GET, 32'h0000_0100, 32'h0000_0000);
    send_word(ACT_GET, 32'h0000_0100, 32'h0000_0000);
    send_word(ACT_PUT, 32'h0000_0400, 32'h0000_0004);
    send_word(ACT_PUT, 32'h0000_0500, 32'h0000_0005);
    send_word(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Zero acts as one with occupancy above it; above the entry count clamps
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_word(ACT_PUT, 32'h0000_0600, 32'h0000_0006);
    send_word(ACT_GET, 32'h0000_0100, 32'h0000_0000);
    write_capacity(5'd31);
    send_word(ACT_PUT, 32'h0000_0700, 32'h0000_0007);
    send_word(ACT_PUT, 32'h0000_0800, 32'h0000_0008);
    send_word(ACT_GET, 32'h0000_0600, 32'h0000_0000);
    write_capacity(5'd16);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n_words,
                                  input bit gaps, input bit stalls);
    int               span;
    logic [KEY_W-1:0] k;
    logic             act;
    write_capacity(cap);
    tx_gap_en   = gaps;
    rx_stall_en = stalls;
    span = effective_capacity(cap) + 4;
    if (span > POOL_N) span = POOL_N;
    for (int n = 0; n < n_words; n++) begin
      // Skew toward low pool indexes so some keys collect many uses
      if ($urandom_range(0, 99) < 85) begin
        k = key_pool[$urandom_range(0, $urandom_range(0, span - 1))];
      end else begin
        k = $urandom;
      end
      act = ($urandom_range(0, 1) == 0) ? ACT_GET : ACT_PUT;
      send_word(act, k, $urandom);
      if ($urandom_range(0, 59) == 0) drain_results();
    end
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps[12];
    caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd3, 5'd16, 5'd12, 5'd2, 5'd24, 5'd16};
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = $urandom;
    end
    key_pool[POOL_N - 2] = 32'h0000_0000;
    key_pool[POOL_N - 1] = 32'hFFFF_FFFF;
    for (int p = 0; p < 12; p++) begin
      run_random_phase(caps[p], 90, (p % 3) != 1, (p % 3) != 1);
    end
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_access();
    test_lru_tiebreak();
    test_capacity_limits();
    test_random_traffic();
    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d words over %0d capacity writes (0 and 31 among them)",
             words_sent, cap_settings);
    $display("Observed %0d hits and %0d evictions", hits_seen, evictions_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding", cache_resp_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> lfu_cache_lru_tiebreak_unit.f
sv/lfuc_pkg.sv
sv/lfuc_store.sv
sv/lfuc_seq.sv
sv/lfu_cache_lru_tiebreak_unit.sv
sv/lfuc_checker.sv
tb/sv/lfu_cache_lru_tiebreak_unit_test.sv
